// File: hdl/assert_macros.svh
// assertion macros shared by the calendar unit rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked only outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("calendar unit assertion failed");
// property checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("calendar unit assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hdl/cds_pkg.sv
// types, constants and calendar helper functions of the calendar unit
// no dependencies; imported by every module of the block
package cds_pkg;

	localparam logic [11:0] FIRST_YEAR = 12'd2001;
	localparam logic [11:0] LAST_YEAR  = 12'd2100;
	localparam logic [4:0]  DEF_DAY    = 5'd9;
	localparam logic [3:0]  DEF_MONTH  = 4'd3;
	localparam logic [11:0] DEF_YEAR   = 12'd2021;
	localparam logic [3:0]  MONTH_JAN  = 4'd1;
	localparam logic [3:0]  MONTH_FEB  = 4'd2;
	localparam logic [3:0]  MONTH_DEC  = 4'd12;

	localparam logic        FUNC_SHIFT = 1'b0;
	localparam logic        FUNC_COUNT = 1'b1;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
	} date_t;

	typedef struct packed {
		logic               func;
		logic [4:0]         day;
		logic [3:0]         month;
		logic [11:0]        year;
		logic signed [15:0] offset;
		logic [4:0]         other_day;
		logic [3:0]         other_month;
		logic [11:0]        other_year;
	} cds_req_t;

	typedef struct packed {
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [11:0] out_year;
		logic [15:0] day_count;
		logic        invalid;
	} cds_rsp_t;

	// leap rule, exact for years 1900 to 2299 (the span the unit ever reaches)
	function automatic logic is_leap(input logic [11:0] y);
		return (y[1:0] == 2'b00) && (y != 12'd1900) && (y != 12'd2100) &&
			(y != 12'd2200);
	endfunction

	// month length, 31 for month codes outside 1 to 12
	function automatic logic [4:0] days_in(input logic [3:0] m, input logic [11:0] y);
		logic [4:0] len;
		case (m)
			4'd2: len = is_leap(y) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// days in the year before the first of month m
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] s;
		case (m)
			4'd2: s = 9'd31;
			4'd3: s = 9'd59;
			4'd4: s = 9'd90;
			4'd5: s = 9'd120;
			4'd6: s = 9'd151;
			4'd7: s = 9'd181;
			4'd8: s = 9'd212;
			4'd9: s = 9'd243;
			4'd10: s = 9'd273;
			4'd11: s = 9'd304;
			4'd12: s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	// date inside 2001 to 2100 with a real month and day
	function automatic logic date_ok(input date_t dt);
		return (dt.year >= FIRST_YEAR) && (dt.year <= LAST_YEAR) &&
			(dt.month >= MONTH_JAN) && (dt.month <= MONTH_DEC) &&
			(dt.day >= 5'd1) && (dt.day <= days_in(dt.month, dt.year));
	endfunction

endpackage

// File: hdl/cds_step.sv
// month stepper: moves a date at most to the first of the next month or the last of the previous month per use
// depends on cds_pkg
module cds_step
	import cds_pkg::*;
(
	input  date_t       cur,
	input  logic [15:0] rem,
	input  logic        back,
	output date_t       nxt,
	output logic [15:0] rem_nxt
);

	logic [4:0]  dim;
	logic [4:0]  prev_dim;
	logic [3:0]  prev_month;
	logic [11:0] prev_year;
	logic [15:0] to_next;
	logic [15:0] day_w;

	// month boundaries on either side
	always_comb begin
		dim     = days_in(cur.month, cur.year);
		day_w   = {11'd0, cur.day};
		to_next = {11'd0, dim} - day_w + 16'd1;
		if (cur.month <= MONTH_JAN) begin
			prev_month = MONTH_DEC;
			prev_year  = cur.year - 12'd1;
		end else begin
			prev_month = cur.month - 4'd1;
			prev_year  = cur.year;
		end
		prev_dim = days_in(prev_month, prev_year);
	end

	// one step: to the next month start, to the previous month end, or finish
	always_comb begin
		nxt     = cur;
		rem_nxt = rem;
		if (rem == 16'd0) begin
			nxt     = cur;
		end else if (!back) begin
			if (rem >= to_next) begin
				rem_nxt = rem - to_next;
				nxt.day = 5'd1;
				if (cur.month >= MONTH_DEC) begin
					nxt.month = MONTH_JAN;
					nxt.year  = cur.year + 12'd1;
				end else begin
					nxt.month = cur.month + 4'd1;
				end
			end else begin
				nxt.day = cur.day + rem[4:0];
				rem_nxt = 16'd0;
			end
		end else begin
			if (rem >= day_w) begin
				rem_nxt   = rem - day_w;
				nxt.month = prev_month;
				nxt.year  = prev_year;
				nxt.day   = prev_dim;
			end else begin
				nxt.day = cur.day - rem[4:0];
				rem_nxt = 16'd0;
			end
		end
	end

endmodule

// File: hdl/cds_daynum.sv
// day number of a valid date, counted from 31 December 2000
// depends on cds_pkg
module cds_daynum
	import cds_pkg::*;
(
	input  date_t       dt,
	output logic [15:0] num
);

	logic [11:0] yoff;
	logic [6:0]  q;
	logic [15:0] year_days;
	logic [15:0] leap_adj;

	// whole years since 2001 plus their leap days, then month and day
	always_comb begin
		yoff      = dt.year - FIRST_YEAR;
		q         = yoff[6:0];
		year_days = {9'd0, q} * 16'd365;
		leap_adj  = ((dt.month > MONTH_FEB) && is_leap(dt.year)) ? 16'd1 : 16'd0;
		num       = year_days + {11'd0, q[6:2]} + {7'd0, month_start(dt.month)} +
			leap_adj + {11'd0, dt.day};
	end

endmodule

// File: hdl/calendar_date_step_and_diff.sv
// shift: the stepper moves the date one month step at a time, each boundary crossed and a final part month
// count: two passes through one day-number unit and one subtract
// one request at a time; busy is high from acceptance until the result strobe
// done is high for one cycle with busy already low; the receiver cannot stall
// asynchronous active-low reset returns to idle with no result pending
`include "assert_macros.svh"
module calendar_date_step_and_diff
	import cds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cds_req_t req,
	output logic     done,
	output cds_rsp_t result
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SHIFT = 4'b0010,
		ST_NUM_A = 4'b0100,
		ST_NUM_B = 4'b1000
	} state_t;

	state_t      state_q;
	logic        done_q;
	cds_rsp_t    res_q;
	date_t       cur_q;
	date_t       other_q;
	logic [15:0] rem_q;
	logic        back_q;
	logic        bad_q;
	logic [15:0] num_a_q;

	date_t       in_a;
	date_t       in_b;
	date_t       chk_a;
	date_t       chk_b;
	logic        ok_a;
	logic        ok_b;
	logic        accept;
	logic [15:0] in_mag;

	date_t       step_nxt;
	logic [15:0] step_rem;
	date_t       dn_in;
	logic [15:0] dn_num;
	logic [15:0] diff;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = res_q;

	// input date checks, failing dates take the default
	always_comb begin
		in_a = '{day: req.day, month: req.month, year: req.year};
		in_b = '{day: req.other_day, month: req.other_month, year: req.other_year};
		ok_a = date_ok(in_a);
		ok_b = date_ok(in_b);
		chk_a = ok_a ? in_a : date_t'{day: DEF_DAY, month: DEF_MONTH, year: DEF_YEAR};
		chk_b = ok_b ? in_b : date_t'{day: DEF_DAY, month: DEF_MONTH, year: DEF_YEAR};
		in_mag = req.offset[15] ? (16'd0 - $unsigned(req.offset)) : $unsigned(req.offset);
	end

	cds_step u_step (
		.cur     (cur_q),
		.rem     (rem_q),
		.back    (back_q),
		.nxt     (step_nxt),
		.rem_nxt (step_rem)
	);

	// shared day-number unit: first date, then second date
	assign dn_in = (state_q == ST_NUM_B) ? other_q : cur_q;

	cds_daynum u_daynum (
		.dt  (dn_in),
		.num (dn_num)
	);

	assign diff = (dn_num >= num_a_q) ? (dn_num - num_a_q) : (num_a_q - dn_num);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (req.func == FUNC_COUNT) ? ST_NUM_A : ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (rem_q == 16'd0) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_NUM_A: begin
					state_q <= ST_NUM_B;
				end
				ST_NUM_B: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cur_q   <= chk_a;
					other_q <= chk_b;
					rem_q   <= (req.func == FUNC_SHIFT) ? in_mag : 16'd0;
					back_q  <= req.offset[15];
					bad_q   <= !ok_a || ((req.func == FUNC_COUNT) && !ok_b);
				end
			end
			ST_SHIFT: begin
				cur_q <= step_nxt;
				rem_q <= step_rem;
				if (rem_q == 16'd0) begin
					res_q <= '{out_day: cur_q.day, out_month: cur_q.month,
						out_year: cur_q.year, day_count: 16'd0, invalid: bad_q};
				end
			end
			ST_NUM_A: begin
				num_a_q <= dn_num;
			end
			ST_NUM_B: begin
				res_q <= '{out_day: cur_q.day, out_month: cur_q.month,
					out_year: cur_q.year, day_count: diff, invalid: bad_q};
			end
			default: begin
				rem_q <= 16'd0;
			end
		endcase
	end

	// a result only follows a busy cycle
	`ASSERT_RST(a_done_after_busy, clk, arst_n, done |-> $past(busy))
	// an accepted request makes the unit busy
	`ASSERT_RST(a_accept_busy, clk, arst_n, accept |=> busy)
	// every month step consumes at least one day
	`ASSERT_RST(a_rem_falls, clk, arst_n, (state_q == ST_SHIFT && rem_q != 16'd0) |=> (rem_q < $past(rem_q)))
	// results always carry a real month
	`ASSERT_RST(a_month_range, clk, arst_n, done |-> (result.out_month >= MONTH_JAN && result.out_month <= MONTH_DEC))
	// no result strobe while a request is being worked
	`ASSERT_RST(a_done_idle, clk, arst_n, done |-> !busy || $past(accept))

endmodule
